// File: design/rdc_pkg.sv
// Package for the radix digit converter: widths, sequencer states, store
// request bundle and the digit-to-ASCII mapping. No dependencies.
package rdc_pkg;

	localparam int VALUE_WIDTH  = 32;
	localparam int STORE_DEPTH  = VALUE_WIDTH;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int COUNT_W      = $clog2(STORE_DEPTH + 1);
	localparam int ITER_W       = $clog2(VALUE_WIDTH);
	localparam int DIGIT_W      = 6;
	localparam int RADIX_W      = 6;
	localparam int CHAR_W       = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 6'd35;
	localparam logic [DIGIT_W-1:0] DEC_DIGITS  = 6'd10;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'h30;  // '0'
	localparam logic [CHAR_W-1:0]  ASCII_ALPHA = 7'h37;  // 'A' - 10

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic               wr_en;
		logic [ADDR_W-1:0]  wr_addr;
		logic [DIGIT_W-1:0] wr_data;
		logic               rd_en;
		logic [ADDR_W-1:0]  rd_addr;
	} store_req_t;

	// digit value to '0'-'9', 'A'-'Z'; out-of-range codes clamp to 'Z'
	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W-1:0] dc;
		dc = (d > DIGIT_MAX) ? DIGIT_MAX : d;
		if (dc < DEC_DIGITS)
			return ASCII_ZERO + CHAR_W'(dc);
		else
			return ASCII_ALPHA + CHAR_W'(dc);
	endfunction

endpackage

// File: design/radix_digit_converter.sv
// Radix digit converter, top level. One division per digit in the shared
// bit-serial divider, each of 32 bit steps; then one output word per cycle,
// the first following the last division through the sequencer state register
// and the registered store read. A new value is accepted only while busy is
// low, after the last word of the previous one. No receiver stall.
// Async reset (arst_n) returns the sequencer to idle and the radix register to 10.
module radix_digit_converter import rdc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// command channel
	input  logic                   start,
	output logic                   busy,
	input  logic [VALUE_WIDTH-1:0] value,
	// radix register write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [RADIX_W-1:0]     cfg_data,
	// digit output
	output logic                   strobe,
	output logic [CHAR_W-1:0]      digit_char,
	output logic                   last_digit
);

	seq_state_t             state_q, state_d;
	logic [RADIX_W-1:0]     radix_q;
	logic [RADIX_W-1:0]     radix_eff;
	logic [COUNT_W-1:0]     cnt_q;      // digits stored so far
	logic [ADDR_W-1:0]      rd_idx_q;   // next digit to read, counts down
	logic                   emit_vld_s1;
	logic                   last_s1;

	logic                   accept;
	logic                   div_start;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic [VALUE_WIDTH-1:0] div_quotient;
	logic [DIGIT_W-1:0]     div_rem;
	logic                   conv_finish;
	store_req_t             store_req;
	logic [DIGIT_W-1:0]     store_rdata;

	// the user must write the register only while idle, which the block leaves unchecked; always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radix_q <= RADIX_RESET;
		else if (cfg_valid && cfg_ready)
			radix_q <= cfg_data;
	end

	// out-of-range radix codes saturate to 2 or 36
	always_comb begin
		if (radix_q < RADIX_MIN)
			radix_eff = RADIX_MIN;
		else if (radix_q > RADIX_MAX)
			radix_eff = RADIX_MAX;
		else
			radix_eff = radix_q;
	end

	assign busy   = (state_q != ST_IDLE) || emit_vld_s1;
	assign accept = start && !busy;

	// conversion ends when the quotient hits zero or the store is full;
	// a zero value still runs one division and stores the single digit 0
	assign conv_finish = div_done &&
		((div_quotient == '0) || (cnt_q == COUNT_W'(STORE_DEPTH - 1)));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_DIV;
			ST_DIV:  if (conv_finish) state_d = ST_EMIT;
			ST_EMIT: if (rd_idx_q == '0) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		div_start         = 1'b0;
		div_dividend      = div_quotient;
		store_req         = '0;
		store_req.wr_addr = cnt_q[ADDR_W-1:0];
		store_req.wr_data = div_rem;
		store_req.rd_addr = rd_idx_q;
		unique case (state_q)
			ST_IDLE: begin
				div_start    = accept;
				div_dividend = value;
			end
			ST_DIV: begin
				store_req.wr_en = div_done;
				div_start       = div_done && !conv_finish;
			end
			ST_EMIT: begin
				store_req.rd_en = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			emit_vld_s1 <= 1'b0;
			last_s1     <= 1'b0;
		end else begin
			state_q     <= state_d;
			emit_vld_s1 <= (state_q == ST_EMIT);
			last_s1     <= (state_q == ST_EMIT) && (rd_idx_q == '0);
			if (accept)
				cnt_q <= '0;
			else if (store_req.wr_en)
				cnt_q <= cnt_q + 1'b1;
			// most significant digit sits at the last written index
			if (state_q == ST_DIV && conv_finish)
				rd_idx_q <= cnt_q[ADDR_W-1:0];
			else if (state_q == ST_EMIT)
				rd_idx_q <= rd_idx_q - 1'b1;
		end
	end

	rdc_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (radix_eff),
		.done      (div_done),
		.quotient  (div_quotient),
		.remainder (div_rem)
	);

	rdc_digit_store u_store (
		.clk     (clk),
		.req     (store_req),
		.rd_data (store_rdata)
	);

	// registered read data maps straight to ASCII
	assign strobe     = emit_vld_s1;
	assign digit_char = digit_ascii(store_rdata);
	assign last_digit = emit_vld_s1 && last_s1;

endmodule

// File: design/rdc_divider.sv
// Restoring bit-serial divider: VALUE_WIDTH-bit dividend by a 6-bit radix,
// one quotient bit per cycle. Depends on rdc_pkg.
module rdc_divider import rdc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [RADIX_W-1:0]     divisor,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] quotient,
	output logic [DIGIT_W-1:0]     remainder
);

	logic                   active_q;
	logic                   done_q;
	logic [ITER_W-1:0]      iter_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [RADIX_W-1:0]     div_q;

	logic [DIGIT_W:0]       trial;
	logic                   fits;
	logic [DIGIT_W:0]       diff;

	always_comb begin
		trial = {rem_q, quo_q[VALUE_WIDTH-1]};
		fits  = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			iter_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				iter_q   <= '0;
			end else if (active_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == ITER_W'(VALUE_WIDTH - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (active_q) begin
			quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
			rem_q <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: design/rdc_digit_store.sv
// Digit store: STORE_DEPTH x 6-bit memory, one write and one registered read
// port. Depends on rdc_pkg.
module rdc_digit_store import rdc_pkg::*; (
	input  logic               clk,
	input  store_req_t         req,
	output logic [DIGIT_W-1:0] rd_data
);

	logic [DIGIT_W-1:0] mem_q [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem_q[req.wr_addr] <= req.wr_data;
	end

	always_ff @(posedge clk) begin
		if (req.rd_en)
			rd_data <= mem_q[req.rd_addr];
	end

endmodule

// File: design/rdc_checker.sv
// Port-level checker for radix_digit_converter, bound to the top level.
// Depends on rdc_pkg.
module rdc_checker import rdc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              strobe,
	input logic [CHAR_W-1:0] digit_char,
	input logic              last_digit
);

	a_word_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("output word while not busy");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy not raised after start");

	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_digit) |=> strobe) else $error("gap inside digit run");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_digit) |=> !strobe) else $error("word after last digit");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ((digit_char >= 7'h30 && digit_char <= 7'h39) ||
		            (digit_char >= 7'h41 && digit_char <= 7'h5A)))
		else $error("digit character out of range");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.strobe     (strobe),
	.digit_char (digit_char),
	.last_digit (last_digit)
);

// File: dv/radix_digit_converter_tb.sv
// Self-checking testbench for radix_digit_converter: directed table, then random values
// over several radix settings, each digit word checked against its typed string or a local model.
// Depends on rdc_pkg and radix_digit_converter only.
`timescale 1ns / 1ps

module radix_digit_converter_tb import rdc_pkg::*; ();

	// one expected digit word
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} digit_word_t;

	// directed table row: either a radix write or one value to convert
	typedef enum logic {
		ROW_RADIX,
		ROW_VALUE
	} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [31:0]      data;
		string            text;  // typed digit string, empty = use the model
	} plan_row_t;

	localparam int RANDOM_ITEMS = 135;
	localparam int PHASE_ITEMS  = 15;
	localparam int IDLE_PCT     = 22;
	localparam int SETTLE_CYC   = 40;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   start     = 1'b0;
	logic [VALUE_WIDTH-1:0] value     = '0;
	logic                   cfg_valid = 1'b0;
	logic [RADIX_W-1:0]     cfg_data  = '0;
	logic                   busy;
	logic                   cfg_ready;
	logic                   strobe;
	logic [CHAR_W-1:0]      digit_char;
	logic                   last_digit;

	// model state: the radix register as the block should hold it
	logic [RADIX_W-1:0] radix_reg = RADIX_RESET;

	digit_word_t digits_due[$];   // digit words still owed by the block
	digit_word_t mon_word;
	plan_row_t   plan[$];

	int          errors         = 0;
	int          items_sent     = 0;
	int          digits_checked = 0;
	logic [63:0] radix_written  = '0;

	radix_digit_converter uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.strobe     (strobe),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop; worst case is far below this
	initial begin
		#20_000_000;
		$display("FAIL radix_digit_converter");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	// digit value to ASCII: '0'..'9', then 'A'..'Z'
	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		logic [7:0] c;
		if (d < 10)
			c = 8'h30 + 8'(d);
		else
			c = 8'h37 + 8'(d);
		return c[CHAR_W-1:0];
	endfunction

	// Repeated division by the clamped radix; remainders come out least
	// significant first, words are queued most significant first.
	function automatic void predict_digits(input logic [VALUE_WIDTH-1:0] v);
		logic [VALUE_WIDTH-1:0] n;
		logic [VALUE_WIDTH-1:0] base;
		logic [DIGIT_W-1:0]     rem [0:STORE_DEPTH-1];
		int                     cnt;
		digit_word_t            w;
		n   = v;
		cnt = 0;
		// register values outside 2..36 saturate
		if (radix_reg < 2)
			base = 2;
		else if (radix_reg > 36)
			base = 36;
		else
			base = VALUE_WIDTH'(radix_reg);
		if (n == 0) begin
			rem[0] = '0;
			cnt = 1;
		end else begin
			while (n != 0 && cnt < STORE_DEPTH) begin
				rem[cnt] = DIGIT_W'(n % base);
				n = n / base;
				cnt++;
			end
		end
		for (int k = cnt - 1; k >= 0; k--) begin
			w.ch   = digit_to_char(rem[k]);
			w.last = (k == 0);
			digits_due.push_back(w);
		end
	endfunction

	// Sender pause, at random unless quiet: lowers start and leaves noise on value. Gap lengths are
	// mostly short, now and then long enough to land late in a conversion.
	task automatic sender_gap(input bit quiet);
		int n;
		if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 1200) : $urandom_range(1, 40);
			start <= 1'b0;
			value <= $urandom;
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold off until every owed word has come and the block is idle.
	task automatic wait_drained();
		if (start)
			start <= 1'b0;
		while (digits_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_radix(input logic [RADIX_W-1:0] r);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= r;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_data  <= RADIX_W'($urandom);
		radix_reg = r;
		radix_written[r] = 1'b1;
	endtask

	// Issue one value; start stays high while the block is busy. Start is
	// not lowered here, so back-to-back items keep it high without a glitch.
	task automatic send_value(input logic [VALUE_WIDTH-1:0] v, input string text);
		digit_word_t w;
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		if (text.len() != 0) begin
			for (int i = 0; i < text.len(); i++) begin
				w.ch   = CHAR_W'(text[i]);
				w.last = (i == text.len() - 1);
				digits_due.push_back(w);
			end
		end else begin
			predict_digits(v);
		end
		items_sent++;
	endtask

	function automatic void add_row(input row_kind_t k, input logic [31:0] d, input string s);
		plan_row_t r;
		r.kind = k;
		r.data = d;
		r.text = s;
		plan.push_back(r);
	endfunction

	// Random value shapes: zero, all ones, single bits, masks, small and full range.
	function automatic logic [VALUE_WIDTH-1:0] pick_value();
		int sh;
		sh = $urandom_range(0, 31);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return VALUE_WIDTH'(1) << sh;
			3:       return (VALUE_WIDTH'(1) << sh) - 1;
			4:       return VALUE_WIDTH'($urandom_range(0, 40));
			5:       return VALUE_WIDTH'($urandom_range(0, 5000));
			default: return $urandom;
		endcase
	endfunction

	// Monitor: the receiver cannot stall, so every strobe is one word.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (digits_due.size() == 0) begin
				report_mismatch($sformatf("unexpected word char=%h last=%b",
					digit_char, last_digit));
			end else begin
				mon_word = digits_due.pop_front();
				digits_checked++;
				if (digit_char !== mon_word.ch)
					report_mismatch($sformatf("digit_char %h, expected %h (%c)",
						digit_char, mon_word.ch, mon_word.ch));
				if (last_digit !== mon_word.last)
					report_mismatch($sformatf("last_digit %b, expected %b",
						last_digit, mon_word.last));
			end
		end
	end

	initial begin
		logic [RADIX_W-1:0] r;
		int                 phase;
		int                 n;

		// directed table; first rows run at the reset radix of ten
		add_row(ROW_VALUE, 32'd0,          "0");
		add_row(ROW_VALUE, 32'd9,          "9");
		add_row(ROW_VALUE, 32'd10,         "10");
		add_row(ROW_VALUE, 32'hFFFF_FFFF,  "4294967295");
		add_row(ROW_RADIX, 32'd2,          "");
		add_row(ROW_VALUE, 32'hFFFF_FFFF,  {4{"11111111"}});
		add_row(ROW_VALUE, 32'd1,          "1");
		add_row(ROW_VALUE, 32'h8000_0000,  "");
		add_row(ROW_RADIX, 32'd36,         "");
		add_row(ROW_VALUE, 32'd35,         "Z");
		add_row(ROW_VALUE, 32'd36,         "10");
		add_row(ROW_VALUE, 32'hFFFF_FFFF,  "");
		// register values below two act as radix two
		add_row(ROW_RADIX, 32'd0,          "");
		add_row(ROW_VALUE, 32'd5,          "101");
		add_row(ROW_RADIX, 32'd1,          "");
		add_row(ROW_VALUE, 32'd2,          "10");
		// values above thirty-six act as thirty-six
		add_row(ROW_RADIX, 32'd63,         "");
		add_row(ROW_VALUE, 32'd35,         "Z");
		add_row(ROW_RADIX, 32'd37,         "");
		add_row(ROW_VALUE, 32'd71,         "1Z");
		add_row(ROW_RADIX, 32'd16,         "");
		add_row(ROW_VALUE, 32'hDEAD_BEEF,  "DEADBEEF");
		add_row(ROW_VALUE, 32'd0,          "0");
		add_row(ROW_VALUE, 32'h1234_5678,  "");

		// reset held from time zero, released once
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_RADIX) begin
				write_radix(plan[i].data[RADIX_W-1:0]);
			end else begin
				send_value(plan[i].data, plan[i].text);
				sender_gap(1'b0);
			end
		end

		// random part: phases of one radix each, extremes first
		phase = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % PHASE_ITEMS == 0) begin
				case (phase)
					0:       r = 6'd2;
					1:       r = 6'd36;
					2:       r = 6'd0;
					3:       r = 6'd63;
					default: r = RADIX_W'($urandom_range(0, 63));
				endcase
				write_radix(r);
				phase++;
			end else if ($urandom_range(0, 19) == 0) begin
				// let the whole backlog drain before the next value
				wait_drained();
			end
			send_value(pick_value(), "");
			// items 50..89 run back to back with no pauses
			sender_gap(i >= 50 && i < 90);
		end

		if (start)
			start <= 1'b0;
		while (digits_due.size() != 0)
			@(posedge clk);
		// catch stray words after the last expected one
		repeat (SETTLE_CYC) @(posedge clk);

		n = $countones(radix_written);
		$display("covered %0d values, %0d digit words checked, %0d radix settings",
			items_sent, digits_checked, n);
		$display("radix extremes 0/1/2/36/37/63 and reset radix ten exercised");
		if (errors == 0) begin
			$display("PASS radix_digit_converter");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAIL radix_digit_converter");
		end
		$finish;
	end

endmodule
